// ===== sv/wts_pkg.sv =====
// Shared types and constants for the WAV stream to 8-bit stereo converter.
`timescale 1ns / 1ps

package wts_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [7:0]  SIGN_FLIP = 8'd128;

    typedef enum logic [1:0] {
        KIND_PAIR   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_INVAL  = 2'd2,
        KIND_NOSUP  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  left_sample;
        logic [7:0]  right_sample;
        logic [31:0] rate_hz;
    } result_t;

endpackage

// ===== sv/wts_parser.sv =====
// Byte-wise RIFF/WAVE parser: header walk, fmt decode and frame sampling.
`timescale 1ns / 1ps

module wts_parser
    import wts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  data_byte,
    output logic        emit,
    output result_t     result
);

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_SUB  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   byte_count_reg, byte_count_next;
    logic [31:0]  tag_word_reg, tag_word_next;
    logic [31:0]  chunk_length_reg, chunk_length_next;
    logic         fmt_seen_reg, fmt_seen_next;
    logic [15:0]  channel_count_reg, channel_count_next;
    logic [31:0]  sample_rate_reg, sample_rate_next;
    logic [15:0]  frame_bytes_reg, frame_bytes_next;
    logic [12:0]  sample_bytes_reg, sample_bytes_next;
    logic [31:0]  data_remaining_reg, data_remaining_next;
    logic [15:0]  frame_offset_reg, frame_offset_next;
    logic [7:0]   held_left_reg, held_left_next;
    logic [7:0]   held_right_reg, held_right_next;

    logic [31:0]  tag_shift;
    logic [31:0]  len_shift;
    logic [15:0]  half;
    logic         stereo;
    logic [16:0]  min_frame;
    logic [16:0]  left_pos;
    logic [16:0]  right_pos;
    logic [16:0]  offset_inc;
    logic [31:0]  skip_dec;
    logic [7:0]   left_out;
    logic [7:0]   right_out;

    assign tag_shift  = {data_byte, tag_word_reg[31:8]};
    assign len_shift  = {data_byte, chunk_length_reg[31:8]};
    assign half       = tag_shift[31:16];
    assign stereo     = (channel_count_reg >= 16'd2);
    assign min_frame  = stereo ? {3'b000, sample_bytes_reg, 1'b0}
                               : {4'b0000, sample_bytes_reg};
    assign left_pos   = {4'b0000, sample_bytes_reg} - 17'd1;
    assign right_pos  = {3'b000, sample_bytes_reg, 1'b0} - 17'd1;
    assign offset_inc = {1'b0, frame_offset_reg} + 17'd1;
    assign skip_dec   = (chunk_length_reg != 32'd0) ? chunk_length_reg - 32'd1
                                                    : chunk_length_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        tag_word_next       = tag_word_reg;
        chunk_length_next   = chunk_length_reg;
        fmt_seen_next       = fmt_seen_reg;
        channel_count_next  = channel_count_reg;
        sample_rate_next    = sample_rate_reg;
        frame_bytes_next    = frame_bytes_reg;
        sample_bytes_next   = sample_bytes_reg;
        data_remaining_next = data_remaining_reg;
        frame_offset_next   = frame_offset_reg;
        held_left_next      = held_left_reg;
        held_right_next     = held_right_reg;
        left_out            = 8'd0;
        right_out           = 8'd0;
        emit                = 1'b0;
        result              = '{kind: KIND_INVAL, left_sample: 8'd0,
                                right_sample: 8'd0, rate_hz: 32'd0};

        unique case (phase_reg)
            PH_RIFF:
            begin
                tag_word_next = tag_shift;
                if (byte_count_reg == 4'd3 && tag_shift != TAG_RIFF)
                begin
                    phase_next = PH_ERR;
                    emit       = 1'b1;
                end
                else if (byte_count_reg == 4'd11)
                begin
                    if (tag_shift != TAG_WAVE)
                    begin
                        phase_next = PH_ERR;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        byte_count_next = 4'd0;
                        phase_next      = PH_SUB;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end

            PH_SUB:
            begin
                if (byte_count_reg < 4'd4)
                    tag_word_next = tag_shift;
                else
                    chunk_length_next = len_shift;
                if (byte_count_reg == 4'd7)
                begin
                    byte_count_next = 4'd0;
                    if (tag_word_reg == TAG_DATA)
                    begin
                        emit = 1'b1;
                        if (!fmt_seen_reg || sample_bytes_reg == 13'd0 ||
                            {1'b0, frame_bytes_reg} < min_frame)
                        begin
                            phase_next = PH_ERR;
                            // Channel check sits between the fmt-present and
                            // sample-size checks.
                            if (fmt_seen_reg && channel_count_reg > 16'd2)
                                result.kind = KIND_NOSUP;
                        end
                        else if (channel_count_reg > 16'd2)
                        begin
                            phase_next  = PH_ERR;
                            result.kind = KIND_NOSUP;
                        end
                        else
                        begin
                            data_remaining_next = len_shift;
                            frame_offset_next   = 16'd0;
                            phase_next          = PH_DATA;
                            result.kind         = KIND_HEADER;
                            result.rate_hz      = sample_rate_reg;
                        end
                    end
                    else if (tag_word_reg == TAG_FMT)
                    begin
                        if (len_shift == 32'd0)
                        begin
                            phase_next = PH_ERR;
                            emit       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                        end
                    end
                    else
                    begin
                        phase_next = (len_shift == 32'd0) ? PH_SUB : PH_SKIP;
                    end
                end
                else
                begin
                    byte_count_next = byte_count_reg + 4'd1;
                end
            end

            PH_FMT:
            begin
                tag_word_next = tag_shift;
                if (byte_count_reg == 4'd1 && half != FMT_PCM)
                begin
                    phase_next = PH_ERR;
                    emit       = 1'b1;
                end
                else
                begin
                    if (byte_count_reg == 4'd3)
                        channel_count_next = half;
                    if (byte_count_reg == 4'd7)
                        sample_rate_next = tag_shift;
                    if (byte_count_reg == 4'd13)
                        frame_bytes_next = half;
                    if (byte_count_reg == 4'd15)
                    begin
                        sample_bytes_next = half[15:3];
                        fmt_seen_next     = 1'b1;
                        byte_count_next   = 4'd0;
                        if (chunk_length_reg > 32'd16)
                        begin
                            chunk_length_next = chunk_length_reg - 32'd16;
                            phase_next        = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_SUB;
                        end
                    end
                    else if (chunk_length_reg == {28'd0, byte_count_reg} + 32'd1)
                    begin
                        // fmt body shorter than 16 bytes
                        phase_next = PH_ERR;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + 4'd1;
                    end
                end
            end

            PH_SKIP:
            begin
                chunk_length_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    byte_count_next = 4'd0;
                    phase_next      = PH_SUB;
                end
            end

            PH_DATA:
            begin
                if (data_remaining_reg != 32'd0)
                begin
                    data_remaining_next = data_remaining_reg - 32'd1;
                    if ({1'b0, frame_offset_reg} == left_pos)
                        held_left_next = data_byte;
                    if (stereo && {1'b0, frame_offset_reg} == right_pos)
                        held_right_next = data_byte;
                    if (offset_inc < {1'b0, frame_bytes_reg})
                    begin
                        frame_offset_next = offset_inc[15:0];
                    end
                    else
                    begin
                        frame_offset_next = 16'd0;
                        left_out  = held_left_next;
                        right_out = stereo ? held_right_next : held_left_next;
                        if (sample_bytes_reg > 13'd1)
                        begin
                            left_out  = left_out + SIGN_FLIP;
                            right_out = right_out + SIGN_FLIP;
                        end
                        emit                = 1'b1;
                        result.kind         = KIND_PAIR;
                        result.left_sample  = left_out;
                        result.right_sample = right_out;
                    end
                end
            end

            PH_ERR:
            begin
                // drop every byte until reset
            end

            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_RIFF;
            byte_count_reg     <= '0;
            tag_word_reg       <= '0;
            chunk_length_reg   <= '0;
            fmt_seen_reg       <= 1'b0;
            channel_count_reg  <= '0;
            sample_rate_reg    <= '0;
            frame_bytes_reg    <= '0;
            sample_bytes_reg   <= '0;
            data_remaining_reg <= '0;
            frame_offset_reg   <= '0;
            held_left_reg      <= '0;
            held_right_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            tag_word_reg       <= tag_word_next;
            chunk_length_reg   <= chunk_length_next;
            fmt_seen_reg       <= fmt_seen_next;
            channel_count_reg  <= channel_count_next;
            sample_rate_reg    <= sample_rate_next;
            frame_bytes_reg    <= frame_bytes_next;
            sample_bytes_reg   <= sample_bytes_next;
            data_remaining_reg <= data_remaining_next;
            frame_offset_reg   <= frame_offset_next;
            held_left_reg      <= held_left_next;
            held_right_reg     <= held_right_next;
        end
    end

endmodule

// ===== sv/wts_out_reg.sv =====
// Result register holding one item for the output channel.
`timescale 1ns / 1ps

module wts_out_reg
    import wts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    emit,
    input  result_t result,
    input  logic    ready,
    output logic    free,
    output logic    valid,
    output result_t held
);

    logic    valid_reg, valid_next;
    result_t held_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign held  = held_reg;

    always_comb
    begin
        valid_next = valid_reg && !ready;
        if (load)
            valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
            held_reg <= result;
    end

endmodule

// ===== sv/wav_stream_to_8bit_stereo.sv =====
// Top level: WAV byte stream in, 8-bit stereo sample pairs and status out.
`timescale 1ns / 1ps

// Usage:
//   Feed the WAV file on the slave channel, one byte per item in s_tdata.
//   The master channel carries at most one result item per input byte:
//   m_tuser holds the kind (sample pair, header accepted, invalid data,
//   not supported) and m_tdata the left byte, right byte and sample rate.
//   A header-accepted item carries the fmt sample rate; an error item is
//   followed by silence, since every later byte is dropped until reset.
// Pipeline and throughput:
//   A byte is captured in the input register when accepted and parsed
//   from there; its result is loaded into the result register when the
//   parser advances and is then valid on the master side. One byte per
//   cycle is sustained while m_tready stays high; the parse is
//   combinational between the input register and the result register.
// Reset:
//   rst_n clears the valid flags of both registers and all parser state;
//   the parser waits for the RIFF tag.
// Stalls:
//   While m_tready is low a waiting result holds in the result register;
//   the parser stops for as long as that register holds an untaken item,
//   the input register then holds its byte and s_tready drops.

module wav_stream_to_8bit_stereo
    import wts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] left_sample, [15:8] right_sample,
                                   // [47:16] rate_hz
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       result_room;
    logic       advance;
    logic       emit;
    result_t    result;
    result_t    held;

    // Parse the held byte whenever the result register can take its item.
    assign advance  = in_valid_reg && result_room;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Capture the incoming byte; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    wts_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .emit      (emit),
        .result    (result)
    );

    wts_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .emit   (emit),
        .result (result),
        .ready  (m_tready),
        .free   (result_room),
        .valid  (m_tvalid),
        .held   (held)
    );

    assign m_tdata = {held.rate_hz, held.right_sample, held.left_sample};
    assign m_tuser = held.kind;

endmodule

// ===== dv/wav_stream_to_8bit_stereo_tb.sv =====
// Self-checking testbench for the WAV stream to 8-bit stereo converter.
`timescale 1ns / 1ps

module wav_stream_to_8bit_stereo_tb;
    import wts_pkg::*;

    // Stream length, idle rate and stall shaping.
    localparam int FILE_LEN     = 450;
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_AT      = 130;   // bytes accepted before the long sink hold
    localparam int HOLD_CYCLES  = 120;
    localparam int STEADY_FROM  = 200;   // window of bytes with no idling on either side
    localparam int STEADY_TO    = 330;
    localparam int DRAIN_CYCLES = 10;
    // Longest correct gap between handshakes is the sink hold plus a few random
    // stalls; take several times that.
    localparam int QUIET_LIMIT  = 1000;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        PARSE_RIFF,
        PARSE_CHUNK_HDR,
        PARSE_FMT,
        PARSE_SKIP,
        PARSE_SAMPLES,
        PARSE_DEAD
    } parse_phase_t;

    // Header outcome that this run's file is built to reach.
    typedef enum int {
        CASE_OK,
        CASE_BAD_RIFF,
        CASE_BAD_WAVE,
        CASE_NOT_PCM,
        CASE_SHORT_FMT,
        CASE_EMPTY_FMT,
        CASE_DATA_FIRST,
        CASE_MANY_CHAN,
        CASE_ZERO_WIDTH,
        CASE_TIGHT_FRAME
    } file_case_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // [7:0] left_sample, [15:8] right_sample, [47:16] rate_hz
    logic [1:0]  m_tuser;            // [1:0] kind

    wav_stream_to_8bit_stereo dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and expectation stores.
    logic [7:0]  file_bytes[$];
    result_t     pending_results[$];
    int unsigned total_bytes = 0;
    int unsigned bytes_in = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    logic        byte_taken = 1'b0;
    logic        sink_hold = 1'b0;
    logic        draining = 1'b0;
    logic        steady;

    assign steady = (bytes_in >= STEADY_FROM) && (bytes_in < STEADY_TO);

    // Predictor state: mirrors the parser registers of the block.
    parse_phase_t parse_phase = PARSE_RIFF;
    logic [31:0]  hdr_pos = '0;
    logic [31:0]  shift_word = '0;
    logic [31:0]  chunk_len = '0;
    logic         have_fmt = 1'b0;
    logic [15:0]  n_chan = '0;
    logic [31:0]  rate_reg = '0;
    logic [15:0]  frame_len = '0;
    logic [12:0]  smp_bytes = '0;
    logic [31:0]  data_left = '0;
    logic [15:0]  frame_pos = '0;
    logic [7:0]   left_hold = '0;
    logic [7:0]   right_hold = '0;

    function automatic void post_result(kind_t k, logic [7:0] l, logic [7:0] r,
                                        logic [31:0] rate);
        result_t res;
        res.kind         = k;
        res.left_sample  = l;
        res.right_sample = r;
        res.rate_hz      = rate;
        pending_results.push_back(res);
    endfunction

    // Report the error and drop every later byte.
    function automatic void abort_parse(kind_t k);
        parse_phase = PARSE_DEAD;
        post_result(k, 8'h00, 8'h00, 32'h0);
    endfunction

    function automatic void close_chunk_header();
        int unsigned chans;
        chans = (n_chan >= 2) ? 2 : 1;
        if (shift_word == TAG_DATA)
        begin
            // Presence of fmt first, then channel support, then sizes.
            if (!have_fmt)
                abort_parse(KIND_INVAL);
            else if (n_chan > 2)
                abort_parse(KIND_NOSUP);
            else if (smp_bytes == 0)
                abort_parse(KIND_INVAL);
            else if (frame_len < smp_bytes * chans)
                abort_parse(KIND_INVAL);
            else
            begin
                data_left   = chunk_len;
                frame_pos   = '0;
                parse_phase = PARSE_SAMPLES;
                post_result(KIND_HEADER, 8'h00, 8'h00, rate_reg);
            end
        end
        else if (shift_word == TAG_FMT)
        begin
            if (chunk_len == 0)
                abort_parse(KIND_INVAL);
            else
            begin
                hdr_pos     = '0;
                parse_phase = PARSE_FMT;
            end
        end
        else
        begin
            hdr_pos     = '0;
            parse_phase = (chunk_len == 0) ? PARSE_CHUNK_HDR : PARSE_SKIP;
        end
    endfunction

    function automatic void take_fmt_byte(logic [7:0] b);
        logic [15:0] half;
        shift_word = {b, shift_word[31:8]};
        half       = shift_word[31:16];
        if (hdr_pos == 1 && half != FMT_PCM)
        begin
            abort_parse(KIND_INVAL);
            return;
        end
        if (hdr_pos == 3)
            n_chan = half;
        if (hdr_pos == 7)
            rate_reg = shift_word;
        if (hdr_pos == 13)
            frame_len = half;
        if (hdr_pos == 15)
        begin
            smp_bytes = half[15:3];
            have_fmt  = 1'b1;
            hdr_pos   = '0;
            // Skip whatever the fmt chunk holds past its 16 bytes.
            if (chunk_len > 16)
            begin
                chunk_len   = chunk_len - 16;
                parse_phase = PARSE_SKIP;
            end
            else
                parse_phase = PARSE_CHUNK_HDR;
        end
        else if (hdr_pos + 1 == chunk_len)
            abort_parse(KIND_INVAL);
        else
            hdr_pos = hdr_pos + 1;
    endfunction

    function automatic void take_sample_byte(logic [7:0] b);
        logic [7:0] l;
        logic [7:0] r;
        if (data_left == 0)
            return;
        data_left = data_left - 1;
        // Capture the top byte of each sample; padding bytes fall through.
        if (frame_pos == smp_bytes - 1)
            left_hold = b;
        if (n_chan >= 2 && frame_pos == 2 * smp_bytes - 1)
            right_hold = b;
        if (frame_pos + 1 < frame_len)
        begin
            frame_pos = frame_pos + 1;
            return;
        end
        frame_pos = '0;
        l = left_hold;
        r = (n_chan >= 2) ? right_hold : left_hold;
        if (smp_bytes > 1)
        begin
            l = l + SIGN_FLIP;
            r = r + SIGN_FLIP;
        end
        post_result(KIND_PAIR, l, r, 32'h0);
    endfunction

    // Advance the predictor by one accepted file byte.
    function automatic void parse_file_byte(logic [7:0] b);
        case (parse_phase)
            PARSE_RIFF:
            begin
                shift_word = {b, shift_word[31:8]};
                if (hdr_pos == 3 && shift_word != TAG_RIFF)
                    abort_parse(KIND_INVAL);
                else if (hdr_pos == 11)
                begin
                    if (shift_word != TAG_WAVE)
                        abort_parse(KIND_INVAL);
                    else
                    begin
                        hdr_pos     = '0;
                        parse_phase = PARSE_CHUNK_HDR;
                    end
                end
                else
                    hdr_pos = hdr_pos + 1;
            end
            PARSE_CHUNK_HDR:
            begin
                if (hdr_pos < 4)
                    shift_word = {b, shift_word[31:8]};
                else
                    chunk_len = {b, chunk_len[31:8]};
                if (hdr_pos == 7)
                begin
                    hdr_pos = '0;
                    close_chunk_header();
                end
                else
                    hdr_pos = hdr_pos + 1;
            end
            PARSE_FMT:
                take_fmt_byte(b);
            PARSE_SKIP:
            begin
                if (chunk_len > 0)
                    chunk_len = chunk_len - 1;
                if (chunk_len == 0)
                begin
                    hdr_pos     = '0;
                    parse_phase = PARSE_CHUNK_HDR;
                end
            end
            PARSE_SAMPLES:
                take_sample_byte(b);
            default:
                ;
        endcase
    endfunction

    // File building helpers: every multi-byte field is little-endian.
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_unknown_chunk();
        int unsigned len;
        len = $urandom_range(0, 5);
        put_le($urandom_range(0, 1) ? 32'h5453_494C : $urandom(), 4);
        put_le(len, 4);
        repeat (len)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_fmt(int unsigned len, logic [15:0] code, logic [15:0] chans,
                                    logic [31:0] rate, logic [15:0] frame, logic [15:0] bits);
        logic [127:0] body;
        body = {bits, frame, $urandom(), rate, chans, code};
        put_le(TAG_FMT, 4);
        put_le(len, 4);
        for (int i = 0; i < len; i++)
            file_bytes.push_back(i < 16 ? body[8*i +: 8] : 8'($urandom_range(0, 255)));
    endfunction

    // Build one file aimed at a randomly chosen header outcome, then pad it
    // with data and trailing bytes up to the stream length.
    task automatic build_file();
        file_case_t  fc;
        int unsigned chans_field;
        int unsigned chans;
        int unsigned bps;
        int unsigned bits;
        int unsigned frame;
        int unsigned flen;
        int unsigned dlen;
        logic [15:0] code;
        logic [31:0] rate;
        logic [7:0]  extremes[4];

        extremes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        fc = ($urandom_range(0, 99) < 75) ? CASE_OK : file_case_t'($urandom_range(1, 9));

        put_le(fc == CASE_BAD_RIFF ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF, 4);
        put_le($urandom(), 4);
        put_le(fc == CASE_BAD_WAVE ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE, 4);

        if (fc == CASE_DATA_FIRST)
        begin
            put_le(TAG_DATA, 4);
            put_le($urandom_range(0, 64), 4);
        end
        repeat ($urandom_range(0, 2))
            put_unknown_chunk();

        // An earlier fmt chunk with wild fields, overwritten by the final one.
        if ($urandom_range(0, 1))
            put_fmt(16 + $urandom_range(0, 2), FMT_PCM, 16'($urandom()), $urandom(),
                    16'($urandom()), 16'($urandom()));

        if (fc == CASE_MANY_CHAN)
            chans_field = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(3, 65534);
        else
            chans_field = $urandom_range(0, 2);
        chans = (chans_field >= 2) ? 2 : 1;
        bps   = (fc == CASE_ZERO_WIDTH) ? 0 : $urandom_range(1, 4);
        bits  = bps * 8 + $urandom_range(0, 7);
        if (fc == CASE_TIGHT_FRAME)
            frame = bps * chans - $urandom_range(1, bps * chans);
        else
            frame = bps * chans + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));

        case (fc)
            CASE_SHORT_FMT: flen = $urandom_range(1, 15);
            CASE_EMPTY_FMT: flen = 0;
            default:        flen = $urandom_range(0, 1) ? 16 : $urandom_range(17, 20);
        endcase

        code = FMT_PCM;
        if (fc == CASE_NOT_PCM)
        begin
            code = $urandom_range(0, 2) == 0 ? 16'h0000 : 16'($urandom());
            if (code == FMT_PCM)
                code = 16'hFFFF;
        end

        case ($urandom_range(0, 3))
            0:       rate = 32'h0000_0000;
            1:       rate = 32'hFFFF_FFFF;
            default: rate = $urandom();
        endcase

        put_fmt(flen, code, 16'(chans_field), rate, 16'(frame), 16'(bits));
        if ($urandom_range(0, 1))
            put_unknown_chunk();

        // Either an exact data length that leaves trailing bytes (and often a
        // partial last frame), or one that outruns the stream.
        if ($urandom_range(0, 4) == 0)
            dlen = 32'hFFFF_FFFF;
        else
            dlen = FILE_LEN - (file_bytes.size() + 8) - $urandom_range(4, 24);
        put_le(TAG_DATA, 4);
        put_le(dlen, 4);

        foreach (extremes[i])
            file_bytes.push_back(extremes[i]);
        while (file_bytes.size() < FILE_LEN)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Print one line per failure and count every one.
    task automatic report_mismatch(string msg);
        fail_count++;
        $display("%0t ns  MISMATCH  %s", $time, msg);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: kind %0d data %h",
                                      m_tuser, m_tdata));
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch($sformatf("kind got %0d expected %s", m_tuser, want.kind.name()));
        if (m_tdata[7:0] !== want.left_sample)
            report_mismatch($sformatf("left_sample got %h expected %h",
                                      m_tdata[7:0], want.left_sample));
        if (m_tdata[15:8] !== want.right_sample)
            report_mismatch($sformatf("right_sample got %h expected %h",
                                      m_tdata[15:8], want.right_sample));
        if (m_tdata[47:16] !== want.rate_hz)
            report_mismatch($sformatf("rate_hz got %h expected %h",
                                      m_tdata[47:16], want.rate_hz));
    endtask

    // Sample both handshakes at the rising edge: predict on each accepted
    // byte, check each accepted result, and watch for a stuck stream.
    always @(posedge clk)
    begin
        byte_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (byte_taken)
            begin
                parse_file_byte(s_tdata);
                bytes_in++;
            end
            if (m_tvalid && m_tready)
                check_result();
            if (byte_taken || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("wav_stream_to_8bit_stereo verification failed");
                    $finish;
                end
            end
        end
    end

    // Source: hold the offered byte until taken, then offer the next one or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || byte_taken))
        begin
            if (file_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= file_bytes.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink: stall at random, never during the steady window or the drain,
    // and always during the long hold.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= !sink_hold &&
                        (draining || steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Long sink hold while the source keeps offering, so the block backs up
    // and drops s_tready.
    initial
    begin
        while (bytes_in < HOLD_AT)
            @(negedge clk);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        build_file();
        total_bytes = file_bytes.size();
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_in != total_bytes)
            @(negedge clk);
        draining = 1'b1;
        while (pending_results.size() != 0)
            @(negedge clk);
        // Let any stray result surface through both registers.
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (fail_count == 0)
            $display("wav_stream_to_8bit_stereo verification clean");
        else
            $display("wav_stream_to_8bit_stereo verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/wts_pkg.sv
sv/wts_parser.sv
sv/wts_out_reg.sv
sv/wav_stream_to_8bit_stereo.sv
dv/wav_stream_to_8bit_stereo_tb.sv
